[hw/rtl/hsv_to_rgb_converter_top_macros.svh]
// assertion macros shared by the hsv to rgb converter rtl
// no dependencies; included by the modules that carry assertions
`ifndef HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HSV_ASSERT_IMPL(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define HSV_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/hsv_pkg.sv]
// types, widths and constants of the hsv to rgb converter
// no dependencies; imported by every module of the block
`default_nettype none

package hsv_pkg;

	localparam int COMPONENT_BITS = 8;
	localparam int HUE_FRACTION_BITS = 6;

	localparam longint SECTOR_DEG = 60;
	localparam longint TURN_DEG = 360;
	// 60 = 15 * 4, the factor of four joins the hue fraction shift
	localparam longint SECTOR_ODD = 15;

	localparam int N = COMPONENT_BITS;
	localparam int HUE_W = 10 + HUE_FRACTION_BITS;
	localparam int SECTORS = 6;
	localparam int SEC_W = 3;

	localparam longint FULL = (longint'(1) << N) - 1;
	localparam longint SPAN = SECTOR_DEG << HUE_FRACTION_BITS;
	localparam longint TURN = TURN_DEG << HUE_FRACTION_BITS;
	localparam longint DEN = FULL * SPAN;
	localparam longint ODD_DEN = FULL * SECTOR_ODD;

	localparam int R_W = $clog2(SPAN);
	localparam int DEN_W = $clog2(DEN + 1);
	localparam int Y_W = N + DEN_W;
	localparam int SH = HUE_FRACTION_BITS + 2;
	localparam int Y1_W = Y_W - SH;

	// floor(x / FULL) estimate: x * (2^N + 1) >> 2N, low by at most one
	localparam longint PM = (longint'(1) << N) + 1;
	localparam int PM_W = N + 1;
	// floor(y / ODD_DEN) estimate: y * M >> Y1_W, low by at most one
	localparam longint RECIP_M = (longint'(1) << Y1_W) / ODD_DEN;
	localparam int M_W = $clog2(RECIP_M + 1);

	localparam logic [SEC_W-1:0] SEC_R2Y = 3'd0;
	localparam logic [SEC_W-1:0] SEC_Y2G = 3'd1;
	localparam logic [SEC_W-1:0] SEC_G2C = 3'd2;
	localparam logic [SEC_W-1:0] SEC_C2B = 3'd3;
	localparam logic [SEC_W-1:0] SEC_B2M = 3'd4;
	localparam logic [SEC_W-1:0] SEC_M2R = 3'd5;

	typedef struct packed {
		logic [HUE_W-1:0] hue_deg;
		logic [N-1:0]     saturation;
		logic [N-1:0]     brightness;
	} hsv_in_t;

	typedef struct packed {
		logic [N-1:0] red;
		logic [N-1:0] green;
		logic [N-1:0] blue;
	} rgb_out_t;

	typedef struct packed {
		logic             valid;
		logic [SEC_W-1:0] sector;
		logic [R_W-1:0]   r;
		logic [R_W-1:0]   rc;
		logic [N-1:0]     sat;
		logic [N-1:0]     val;
	} sec_word_t;

	typedef struct packed {
		logic             valid;
		logic [SEC_W-1:0] sector;
		logic [N-1:0]     val;
		logic [2*N-1:0]   yp;
		logic [Y_W-1:0]   yq;
		logic [Y_W-1:0]   yt;
	} prod_word_t;

	typedef struct packed {
		logic             valid;
		logic [SEC_W-1:0] sector;
		logic [N-1:0]     val;
		logic [N-1:0]     p;
		logic [N-1:0]     q;
		logic [N-1:0]     t;
	} chan_word_t;

endpackage

`default_nettype wire

[hw/rtl/hsv_sector.sv]
// stage 1: hue wrap, sector and in-sector remainder
// depends on hsv_pkg
`default_nettype none

module hsv_sector (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  hsv_pkg::hsv_in_t  hsv,
	output hsv_pkg::sec_word_t sec_s1
);
	import hsv_pkg::*;

	logic [HUE_W-1:0] hue_c;
	logic [HUE_W-1:0] base;
	logic [SEC_W-1:0] sector;
	logic [R_W-1:0]   r;

	always_comb begin
		hue_c = (hsv.hue_deg >= HUE_W'(TURN)) ? '0 : hsv.hue_deg;
		sector = SEC_R2Y;
		base = '0;
		// independent threshold compares, highest passing one wins
		for (int k = 1; k < SECTORS; k++) begin
			if (hue_c >= HUE_W'(longint'(k) * SPAN)) begin
				sector = SEC_W'(k);
				base = HUE_W'(longint'(k) * SPAN);
			end
		end
		r = R_W'(hue_c - base);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_s1 <= '0;
		end else begin
			sec_s1.valid <= start;
			sec_s1.sector <= sector;
			sec_s1.r <= r;
			sec_s1.rc <= R_W'(SPAN) - r;
			sec_s1.sat <= hsv.saturation;
			sec_s1.val <= hsv.brightness;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/hsv_mul.sv]
// stages 2 and 3: saturation products, then brightness products
// depends on hsv_pkg
`default_nettype none

module hsv_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  hsv_pkg::sec_word_t  sec_s1,
	output hsv_pkg::prod_word_t prod_s3
);
	import hsv_pkg::*;

	logic [DEN_W-1:0] sr;
	logic [DEN_W-1:0] src;

	logic             valid_s2;
	logic [SEC_W-1:0] sector_s2;
	logic [N-1:0]     val_s2;
	logic [N-1:0]     xp_s2;
	logic [DEN_W-1:0] xq_s2;
	logic [DEN_W-1:0] xt_s2;

	assign sr = DEN_W'(sec_s1.sat) * DEN_W'(sec_s1.r);
	assign src = DEN_W'(sec_s1.sat) * DEN_W'(sec_s1.rc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			prod_s3 <= '0;
		end else begin
			valid_s2 <= sec_s1.valid;
			prod_s3.valid <= valid_s2;
			prod_s3.sector <= sector_s2;
			prod_s3.val <= val_s2;
			prod_s3.yp <= (2*N)'(val_s2) * (2*N)'(xp_s2);
			prod_s3.yq <= Y_W'(val_s2) * Y_W'(xq_s2);
			prod_s3.yt <= Y_W'(val_s2) * Y_W'(xt_s2);
		end
	end

	always_ff @(posedge clk) begin
		sector_s2 <= sec_s1.sector;
		val_s2 <= sec_s1.val;
		xp_s2 <= N'(FULL) - sec_s1.sat;
		xq_s2 <= DEN_W'(DEN) - sr;
		xt_s2 <= DEN_W'(DEN) - src;
	end

endmodule

`default_nettype wire

[hw/rtl/hsv_div.sv]
// stages 4 and 5: truncating division by the constant scales
// reciprocal estimate, then one compare-and-add correction; depends on hsv_pkg
`default_nettype none

`include "hsv_to_rgb_converter_top_macros.svh"

module hsv_div (
	input  logic               clk,
	input  logic               arst_n,
	input  hsv_pkg::prod_word_t prod_s3,
	output hsv_pkg::chan_word_t chan_s5
);
	import hsv_pkg::*;

	logic [2*N+PM_W-1:0]  pp;
	logic [Y1_W+M_W-1:0]  pq;
	logic [Y1_W+M_W-1:0]  pt;
	logic [Y1_W-1:0]      yq1;
	logic [Y1_W-1:0]      yt1;

	logic             valid_s4;
	logic [SEC_W-1:0] sector_s4;
	logic [N-1:0]     val_s4;
	logic [2*N-1:0]   yp_s4;
	logic [Y1_W-1:0]  yq_s4;
	logic [Y1_W-1:0]  yt_s4;
	logic [N-1:0]     ep_s4;
	logic [N-1:0]     eq_s4;
	logic [N-1:0]     et_s4;

	logic [2*N-1:0]   rem_p;
	logic [Y1_W-1:0]  rem_q;
	logic [Y1_W-1:0]  rem_t;

	// low bits of the divisor are a power of two
	assign yq1 = prod_s3.yq[Y_W-1:SH];
	assign yt1 = prod_s3.yt[Y_W-1:SH];

	assign pp = (2*N+PM_W)'(prod_s3.yp) * (2*N+PM_W)'(PM);
	assign pq = (Y1_W+M_W)'(yq1) * (Y1_W+M_W)'(RECIP_M);
	assign pt = (Y1_W+M_W)'(yt1) * (Y1_W+M_W)'(RECIP_M);

	assign rem_p = yp_s4 - (2*N)'(ep_s4) * (2*N)'(FULL);
	assign rem_q = yq_s4 - Y1_W'(eq_s4) * Y1_W'(ODD_DEN);
	assign rem_t = yt_s4 - Y1_W'(et_s4) * Y1_W'(ODD_DEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			chan_s5 <= '0;
		end else begin
			valid_s4 <= prod_s3.valid;
			chan_s5.valid <= valid_s4;
			chan_s5.sector <= sector_s4;
			chan_s5.val <= val_s4;
			chan_s5.p <= (rem_p >= (2*N)'(FULL)) ? N'(ep_s4 + 1'b1) : ep_s4;
			chan_s5.q <= (rem_q >= Y1_W'(ODD_DEN)) ? N'(eq_s4 + 1'b1) : eq_s4;
			chan_s5.t <= (rem_t >= Y1_W'(ODD_DEN)) ? N'(et_s4 + 1'b1) : et_s4;
		end
	end

	always_ff @(posedge clk) begin
		sector_s4 <= prod_s3.sector;
		val_s4 <= prod_s3.val;
		yp_s4 <= prod_s3.yp;
		yq_s4 <= yq1;
		yt_s4 <= yt1;
		ep_s4 <= N'(pp >> (2*N));
		eq_s4 <= N'(pq >> Y1_W);
		et_s4 <= N'(pt >> Y1_W);
	end

	`HSV_ASSERT_NEXT(a_chan_below_value, clk, arst_n, valid_s4, (chan_s5.p <= chan_s5.val) && (chan_s5.q <= chan_s5.val) && (chan_s5.t <= chan_s5.val), "channel quotient above brightness")
	`HSV_ASSERT_NEXT(a_p_is_smallest, clk, arst_n, valid_s4, (chan_s5.p <= chan_s5.q) && (chan_s5.p <= chan_s5.t), "p quotient above q or t")

endmodule

`default_nettype wire

[hw/rtl/hsv_to_rgb_converter_top.sv]
// hsv to rgb converter, top level: sector stage, products, division, channel select
// depends on hsv_pkg, hsv_sector, hsv_mul, hsv_div and the assertion macro header
//
// One color word goes in per clock: start is taken whenever busy is low, and busy
// never rises, since the six-stage pipeline has no stall point. Each result is
// shown on rgb for one cycle with done high; the receiver must take it then. The
// stages are hue sector, saturation products, brightness products, reciprocal
// estimate, correction and channel select, each one register stage.
`default_nettype none

`include "hsv_to_rgb_converter_top_macros.svh"

module hsv_to_rgb_converter_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hsv_pkg::hsv_in_t  hsv,
	output logic              done,
	output hsv_pkg::rgb_out_t rgb
);
	import hsv_pkg::*;

	sec_word_t  sec_s1;
	prod_word_t prod_s3;
	chan_word_t chan_s5;
	rgb_out_t   rgb_next;
	logic       done_s6;
	rgb_out_t   rgb_s6;

	assign busy = 1'b0;

	hsv_sector u_sector (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && !busy),
		.hsv    (hsv),
		.sec_s1 (sec_s1)
	);

	hsv_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.sec_s1  (sec_s1),
		.prod_s3 (prod_s3)
	);

	hsv_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.prod_s3 (prod_s3),
		.chan_s5 (chan_s5)
	);

	always_comb begin
		case (chan_s5.sector)
			SEC_R2Y: rgb_next = '{red: chan_s5.val, green: chan_s5.t, blue: chan_s5.p};
			SEC_Y2G: rgb_next = '{red: chan_s5.q, green: chan_s5.val, blue: chan_s5.p};
			SEC_G2C: rgb_next = '{red: chan_s5.p, green: chan_s5.val, blue: chan_s5.t};
			SEC_C2B: rgb_next = '{red: chan_s5.p, green: chan_s5.q, blue: chan_s5.val};
			SEC_B2M: rgb_next = '{red: chan_s5.t, green: chan_s5.p, blue: chan_s5.val};
			default: rgb_next = '{red: chan_s5.val, green: chan_s5.p, blue: chan_s5.q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
		end else begin
			done_s6 <= chan_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		rgb_s6 <= rgb_next;
	end

	assign done = done_s6;
	assign rgb = rgb_s6;

	`HSV_ASSERT_IMPL(a_peak_is_value, clk, arst_n, done, (rgb.red == $past(chan_s5.val)) || (rgb.green == $past(chan_s5.val)) || (rgb.blue == $past(chan_s5.val)), "no channel carries the brightness")
	`HSV_ASSERT_IMPL(a_rgb_below_value, clk, arst_n, done, (rgb.red <= $past(chan_s5.val)) && (rgb.green <= $past(chan_s5.val)) && (rgb.blue <= $past(chan_s5.val)), "channel above brightness")
	`HSV_ASSERT_IMPL(a_red_sector_red, clk, arst_n, done && ($past(chan_s5.sector) == SEC_R2Y), rgb.red == $past(chan_s5.val), "red not full in red sector")

endmodule

`default_nettype wire
